### src/rf_power_deadband_loop_defines.svh
`ifndef RF_POWER_DEADBAND_LOOP_DEFINES_SVH
`define RF_POWER_DEADBAND_LOOP_DEFINES_SVH

// same-cycle implication
`define RPDL_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rpdl assertion failed");

// next-cycle implication
`define RPDL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rpdl assertion failed");

`endif

### src/rpdl_pkg.sv
`default_nettype none

package rpdl_pkg;

    localparam int DATA_W    = 10;
    localparam int READ_W    = 6;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_TARGET    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_TARGET     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_INVERT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HILO_REFERENCE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COT_SELECT     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PWR_SELECT     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MANUAL_ENABLE  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_MANUAL_CODE    = 3'd7;

    localparam int DEAD_BAND       = 6;
    localparam int TABLE_INTERVALS = 20;

    localparam logic [DATA_W-1:0] DRIVE_UP_LIMIT   = 10'd1010;
    localparam logic [DATA_W-1:0] DRIVE_DOWN_LIMIT = 10'd150;
    localparam logic [DATA_W-1:0] DRIVE_MAX        = 10'd1023;

    localparam logic [DATA_W-1:0] BOUND_TAB [TABLE_INTERVALS+1] = '{
        10'd80,  10'd102, 10'd118, 10'd127, 10'd143, 10'd167, 10'd183,
        10'd208, 10'd226, 10'd257, 10'd288, 10'd322, 10'd360, 10'd400,
        10'd446, 10'd505, 10'd564, 10'd645, 10'd722, 10'd818, 10'd992
    };

    localparam logic [READ_W-1:0] READING_TAB [TABLE_INTERVALS] = '{
        6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29,
        6'd30, 6'd31, 6'd32, 6'd33, 6'd34, 6'd35, 6'd36, 6'd37, 6'd38, 6'd39
    };

    typedef struct packed {
        logic [DATA_W-1:0] high_target;
        logic [DATA_W-1:0] low_target;
        logic              level_invert;
        logic              hilo_reference;
        logic              cot_select;
        logic              pwr_select;
        logic              manual_enable;
        logic [DATA_W-1:0] manual_code;
    } t_cfg;

    typedef struct packed {
        logic [DATA_W-1:0] adc_sample;
        logic              standby_level;
        logic              hilo_level;
        logic              tick_100ms;
    } t_req;

    typedef struct packed {
        logic              dac_write;
        logic [DATA_W-1:0] dac_code;
        logic              power_enable;
        logic              reinit_request;
        logic              power_valid;
        logic [READ_W-1:0] power_reading;
    } t_res;

    typedef struct packed {
        logic [DATA_W-1:0] drive_code;
        logic              enable_prev;
    } t_loop_state;

    function automatic logic [READ_W-1:0] power_lookup(input logic [DATA_W-1:0] sample);
        logic [READ_W-1:0] reading;
        reading = '0;
        for (int i = 0; i < TABLE_INTERVALS; i++) begin
            if (sample >= BOUND_TAB[i] && sample < BOUND_TAB[i+1]) begin
                reading = READING_TAB[i];
            end
        end
        return reading;
    endfunction

endpackage

`default_nettype wire

### src/rpdl_in_if.sv
`default_nettype none

interface rpdl_in_if
    import rpdl_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] adc_sample;
    logic              standby_level;
    logic              hilo_level;
    logic              tick_100ms;

    modport source (
        output valid, adc_sample, standby_level, hilo_level, tick_100ms,
        input  ready
    );
    modport sink (
        input  valid, adc_sample, standby_level, hilo_level, tick_100ms,
        output ready
    );
endinterface

`default_nettype wire

### src/rpdl_out_if.sv
`default_nettype none

interface rpdl_out_if
    import rpdl_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              dac_write;
    logic [DATA_W-1:0] dac_code;
    logic              power_enable;
    logic              reinit_request;
    logic              power_valid;
    logic [READ_W-1:0] power_reading;

    modport source (
        output valid, dac_write, dac_code, power_enable, reinit_request,
               power_valid, power_reading,
        input  ready
    );
    modport sink (
        input  valid, dac_write, dac_code, power_enable, reinit_request,
               power_valid, power_reading,
        output ready
    );
endinterface

`default_nettype wire

### src/rpdl_step.sv
`default_nettype none

module rpdl_step
    import rpdl_pkg::*;
(
    input  t_req        i_req,
    input  t_cfg        i_cfg,
    input  t_loop_state i_state,
    output t_res        o_res,
    output t_loop_state o_state
);

    localparam logic signed [DATA_W:0] DB_POS = (DATA_W+1)'(DEAD_BAND);
    localparam logic signed [DATA_W:0] DB_NEG = -DB_POS;
    localparam logic [DATA_W:0]        STEP   = (DATA_W+1)'(DEAD_BAND / 2);

    logic                     en;
    logic                     rise;
    logic                     zero_wr;
    logic                     sel;
    logic [DATA_W-1:0]        target;
    logic signed [DATA_W:0]   diff;
    logic                     out_band;
    logic [DATA_W-1:0]        drv_start;
    logic [DATA_W-1:0]        drv_next;
    logic [DATA_W:0]          drv_up;
    logic [READ_W-1:0]        reading;

    assign en        = i_req.standby_level ^ (i_cfg.cot_select == i_cfg.pwr_select);
    assign rise      = !i_state.enable_prev && en;
    assign zero_wr   = !en && i_cfg.cot_select;
    assign sel       = i_cfg.level_invert ^ (i_req.hilo_level == i_cfg.hilo_reference);
    assign target    = sel ? i_cfg.low_target : i_cfg.high_target;
    assign diff      = $signed({1'b0, i_req.adc_sample}) - $signed({1'b0, target});
    assign out_band  = (diff > DB_POS) || (diff < DB_NEG);
    assign drv_start = rise ? '0 : i_state.drive_code;
    assign drv_up    = {1'b0, drv_start} + STEP;
    assign reading   = power_lookup(i_req.adc_sample);

    always_comb begin
        drv_next = drv_start;
        if (out_band) begin
            if (diff < 0) begin
                if (drv_start <= DRIVE_UP_LIMIT) begin
                    drv_next = drv_up[DATA_W] ? DRIVE_MAX : drv_up[DATA_W-1:0];
                end
            end else if (drv_start >= DRIVE_DOWN_LIMIT) begin
                drv_next = drv_start - STEP[DATA_W-1:0];
            end
        end
    end

    always_comb begin
        o_res   = '0;
        o_state = i_state;
        if (i_cfg.manual_enable) begin
            o_res.power_enable = i_state.enable_prev;
            if (i_req.tick_100ms) begin
                o_res.dac_write     = 1'b1;
                o_res.dac_code      = i_cfg.manual_code;
                o_res.power_valid   = 1'b1;
                o_res.power_reading = reading;
            end
        end else begin
            o_res.power_enable   = en;
            o_res.reinit_request = rise;
            o_res.power_valid    = 1'b1;
            o_res.power_reading  = reading;
            o_res.dac_write      = zero_wr || out_band;
            o_res.dac_code       = out_band ? drv_next : '0;
            o_state.drive_code   = drv_next;
            o_state.enable_prev  = en;
        end
    end

endmodule

`default_nettype wire

### src/rf_power_deadband_loop.sv
// rf power deadband loop
// requests arrive on i_in (valid/ready): one converter sample with the standby,
// high/low and 100 ms tick discretes. every request yields exactly one result on
// o_out: dac write strobe and code, amplifier enable, reinit flag, power reading.
// configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data while idle;
// the user is bound to this; the block does not enforce it. each accepted request
// moves from the input register to the result register, which drives o_out.valid.
// throughput: one request per cycle while o_out.ready keeps up; one pass of loop
// logic feeds the result register, and the drive state updates on that same edge.
// i_in.ready is high while the input register is empty or moves on into the
// result register, so a new request is taken while a finished result still waits.
// when the receiver stalls, the result holds, the input register fills, then
// i_in.ready drops until the result is taken.
// synchronous reset clears the configuration, drive code, enable history and
// both valid flags.
`default_nettype none

module rf_power_deadband_loop
    import rpdl_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [DATA_W-1:0]    i_cfg_data,
    rpdl_in_if.sink                   i_in,
    rpdl_out_if.source                o_out
);

    t_cfg        r_cfg;
    t_cfg        n_cfg;
    logic        r_in_vld;
    t_req        r_in;
    logic        r_out_vld;
    t_res        r_out;
    t_loop_state r_state;
    t_res        step_res;
    t_loop_state step_state;
    logic        advance;
    logic        in_fire;

    assign advance  = !r_out_vld || o_out.ready;
    assign i_in.ready = !r_in_vld || advance;
    assign in_fire  = i_in.valid && i_in.ready;

    rpdl_step u_step (
        .i_req   (r_in),
        .i_cfg   (r_cfg),
        .i_state (r_state),
        .o_res   (step_res),
        .o_state (step_state)
    );

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_HIGH_TARGET:    n_cfg.high_target    = i_cfg_data;
                CFG_LOW_TARGET:     n_cfg.low_target     = i_cfg_data;
                CFG_LEVEL_INVERT:   n_cfg.level_invert   = i_cfg_data[0];
                CFG_HILO_REFERENCE: n_cfg.hilo_reference = i_cfg_data[0];
                CFG_COT_SELECT:     n_cfg.cot_select     = i_cfg_data[0];
                CFG_PWR_SELECT:     n_cfg.pwr_select     = i_cfg_data[0];
                CFG_MANUAL_ENABLE:  n_cfg.manual_enable  = i_cfg_data[0];
                CFG_MANUAL_CODE:    n_cfg.manual_code    = i_cfg_data;
                default:            n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg     <= '0;
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_state   <= '0;
        end else begin
            r_cfg <= n_cfg;
            if (i_in.ready) begin
                r_in_vld <= i_in.valid;
            end
            if (advance) begin
                r_out_vld <= r_in_vld;
                if (r_in_vld) begin
                    r_state <= step_state;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in.adc_sample    <= i_in.adc_sample;
            r_in.standby_level <= i_in.standby_level;
            r_in.hilo_level    <= i_in.hilo_level;
            r_in.tick_100ms    <= i_in.tick_100ms;
        end
        if (advance && r_in_vld) begin
            r_out <= step_res;
        end
    end

    assign o_out.valid          = r_out_vld;
    assign o_out.dac_write      = r_out.dac_write;
    assign o_out.dac_code       = r_out.dac_code;
    assign o_out.power_enable   = r_out.power_enable;
    assign o_out.reinit_request = r_out.reinit_request;
    assign o_out.power_valid    = r_out.power_valid;
    assign o_out.power_reading  = r_out.power_reading;

endmodule

`default_nettype wire

### src/rpdl_chk.sv
`default_nettype none
`include "rf_power_deadband_loop_defines.svh"

module rpdl_chk
    import rpdl_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_out_valid,
    input wire logic              i_out_ready,
    input wire logic              i_dac_write,
    input wire logic [DATA_W-1:0] i_dac_code,
    input wire logic              i_power_enable,
    input wire logic              i_reinit_request,
    input wire logic              i_power_valid,
    input wire logic [READ_W-1:0] i_power_reading
);

    logic                     stall;
    logic [DATA_W+READ_W:0]   payload;
    logic                     reinit_seen;
    logic                     reading_seen;
    logic                     reading_ok;
    logic                     idle_step;
    logic                     quiet;

    assign stall        = i_out_valid && !i_out_ready;
    assign payload      = {i_dac_write, i_dac_code, i_power_reading};
    assign reinit_seen  = i_out_valid && i_reinit_request;
    assign reading_seen = i_out_valid && (i_power_reading != '0);
    assign reading_ok   = i_power_valid && (i_power_reading >= READING_TAB[0])
                          && (i_power_reading <= READING_TAB[TABLE_INTERVALS-1]);
    assign idle_step    = i_out_valid && !i_power_valid;
    assign quiet        = !i_dac_write && (i_dac_code == '0) && (i_power_reading == '0);

    `RPDL_ASSERT_NEXT(a_out_valid_holds, i_clk, i_rst_n, stall, i_out_valid)
    `RPDL_ASSERT_NEXT(a_out_payload_holds, i_clk, i_rst_n, stall, $stable(payload))
    `RPDL_ASSERT_NOW(a_reinit_needs_enable, i_clk, i_rst_n, reinit_seen, i_power_enable)
    `RPDL_ASSERT_NOW(a_reading_in_table, i_clk, i_rst_n, reading_seen, reading_ok)
    `RPDL_ASSERT_NOW(a_idle_step_quiet, i_clk, i_rst_n, idle_step, quiet)

endmodule

bind rf_power_deadband_loop rpdl_chk u_rpdl_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_dac_write      (o_out.dac_write),
    .i_dac_code       (o_out.dac_code),
    .i_power_enable   (o_out.power_enable),
    .i_reinit_request (o_out.reinit_request),
    .i_power_valid    (o_out.power_valid),
    .i_power_reading  (o_out.power_reading)
);

`default_nettype wire

### tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import rpdl_pkg::*;

    localparam int RESET_CYCLES   = 7;
    localparam int GAP_MAX        = 19;
    localparam int NUM_CFG_REGS   = 8;
    localparam int CODE_MAX       = (1 << DATA_W) - 1;
    localparam int CEILING_ITEMS  = 345;
    localparam int RAMP_UP_ITEMS  = 60;
    localparam int RAMP_DN_ITEMS  = 15;
    localparam int PHASES         = 5;
    localparam int PHASE_ITEMS    = 20;
    localparam int SETTLE_CYCLES  = 4;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int REPORT_CAP     = 100;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [DATA_W-1:0] cfg_data;

    rpdl_in_if  in_bus ();
    rpdl_out_if out_bus ();

    rf_power_deadband_loop dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_bus),
        .o_out      (out_bus)
    );

    always #5 clk = ~clk;

    // loop shadow state
    t_cfg              cfg_shadow    = '0;
    logic [DATA_W-1:0] drive_shadow  = '0;
    logic              enable_shadow = 1'b0;
    t_res              loop_result_q[$];

    int err_count = 0;
    bit src_no_gaps = 1'b0;
    bit snk_no_stalls = 1'b0;

    task automatic report_mismatch(string what, int got, int want);
        err_count++;
        if (err_count <= REPORT_CAP) begin
            $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
        end
    endtask

    function automatic logic [READ_W-1:0] power_band(logic [DATA_W-1:0] s);
        logic [READ_W-1:0] r;
        r = '0;
        if (s >= BOUND_TAB[0] && s < BOUND_TAB[TABLE_INTERVALS]) begin
            for (int i = 0; i < TABLE_INTERVALS; i++) begin
                if (s >= BOUND_TAB[i]) begin
                    r = READING_TAB[i];
                end
            end
        end
        return r;
    endfunction

    function automatic t_res loop_step(t_req r);
        t_res e;
        logic en;
        logic sel;
        int   diff;
        int   drv;
        e = '0;
        if (cfg_shadow.manual_enable) begin
            e.power_enable = enable_shadow;
            if (r.tick_100ms) begin
                e.dac_write     = 1'b1;
                e.dac_code      = cfg_shadow.manual_code;
                e.power_valid   = 1'b1;
                e.power_reading = power_band(r.adc_sample);
            end
        end else begin
            e.power_valid   = 1'b1;
            e.power_reading = power_band(r.adc_sample);
            en = r.standby_level ^ (cfg_shadow.cot_select == cfg_shadow.pwr_select);
            e.power_enable = en;
            if (!en && cfg_shadow.cot_select) begin
                e.dac_write = 1'b1;
                e.dac_code  = '0;
            end
            if (!enable_shadow && en) begin
                e.reinit_request = 1'b1;
                drive_shadow     = '0;
            end
            enable_shadow = en;
            sel  = cfg_shadow.level_invert ^ (r.hilo_level == cfg_shadow.hilo_reference);
            diff = int'(r.adc_sample)
                 - int'(sel ? cfg_shadow.low_target : cfg_shadow.high_target);
            if (diff > DEAD_BAND || diff < -DEAD_BAND) begin
                drv = int'(drive_shadow);
                if (diff < 0) begin
                    if (drv <= int'(DRIVE_UP_LIMIT)) begin
                        drv = drv + DEAD_BAND / 2;
                        if (drv > int'(DRIVE_MAX)) begin
                            drv = int'(DRIVE_MAX);
                        end
                    end
                end else if (drv >= int'(DRIVE_DOWN_LIMIT)) begin
                    drv = drv - DEAD_BAND / 2;
                end
                drive_shadow = DATA_W'(drv);
                e.dac_write  = 1'b1;
                e.dac_code   = drive_shadow;
            end
        end
        return e;
    endfunction

    task automatic send_req(logic [DATA_W-1:0] adc, logic stby, logic hilo, logic tick);
        t_req r;
        int   gap;
        r.adc_sample    = adc;
        r.standby_level = stby;
        r.hilo_level    = hilo;
        r.tick_100ms    = tick;
        gap = src_no_gaps ? 0 : $urandom_range(0, GAP_MAX);
        if (gap > 0) begin
            in_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_bus.valid         <= 1'b1;
        in_bus.adc_sample    <= adc;
        in_bus.standby_level <= stby;
        in_bus.hilo_level    <= hilo;
        in_bus.tick_100ms    <= tick;
        @(posedge clk);
        while (in_bus.ready !== 1'b1) @(posedge clk);
        loop_result_q.push_back(loop_step(r));
    endtask

    // drop valid and wait until every result is back
    task automatic settle();
        in_bus.valid <= 1'b0;
        while (loop_result_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apply_cfg(t_cfg c);
        logic [DATA_W-1:0] noise;
        logic [DATA_W-1:0] wdata;
        for (int k = 0; k < NUM_CFG_REGS; k++) begin
            noise = DATA_W'($urandom);
            case (CFG_IDX_W'(k))
                CFG_HIGH_TARGET:    wdata = c.high_target;
                CFG_LOW_TARGET:     wdata = c.low_target;
                CFG_LEVEL_INVERT:   wdata = {noise[DATA_W-1:1], c.level_invert};
                CFG_HILO_REFERENCE: wdata = {noise[DATA_W-1:1], c.hilo_reference};
                CFG_COT_SELECT:     wdata = {noise[DATA_W-1:1], c.cot_select};
                CFG_PWR_SELECT:     wdata = {noise[DATA_W-1:1], c.pwr_select};
                CFG_MANUAL_ENABLE:  wdata = {noise[DATA_W-1:1], c.manual_enable};
                default:            wdata = c.manual_code;
            endcase
            cfg_we   <= 1'b1;
            cfg_idx  <= CFG_IDX_W'(k);
            cfg_data <= wdata;
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        @(posedge clk);
        cfg_shadow = c;
    endtask

    function automatic logic [DATA_W-1:0] pick_code();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return DATA_W'(CODE_MAX);
            default: return DATA_W'($urandom_range(0, CODE_MAX));
        endcase
    endfunction

    task automatic test_deadband_edges();
        t_cfg c;
        c = '0;
        c.high_target = 10'd500;
        c.low_target  = 10'd200;
        apply_cfg(c);
        // enable low, high target, edges of the deadband
        send_req(10'd494, 1'b1, 1'b1, 1'b0);
        send_req(10'd506, 1'b1, 1'b1, 1'b0);
        send_req(10'd493, 1'b1, 1'b1, 1'b0);
        send_req(10'd507, 1'b1, 1'b1, 1'b0);
        // enable rises, drive cleared
        send_req(10'd1023, 1'b0, 1'b1, 1'b1);
        // low target, table boundaries
        send_req(10'd0, 1'b0, 1'b0, 1'b0);
        send_req(10'd79, 1'b0, 1'b0, 1'b1);
        send_req(10'd80, 1'b0, 1'b0, 1'b0);
        send_req(10'd101, 1'b0, 1'b0, 1'b0);
        send_req(10'd102, 1'b0, 1'b0, 1'b1);
        send_req(10'd991, 1'b0, 1'b0, 1'b0);
        send_req(10'd992, 1'b0, 1'b0, 1'b0);
        settle();
    endtask

    task automatic test_zero_write_and_manual();
        t_cfg c;
        c = '0;
        c.high_target    = DATA_W'(CODE_MAX);
        c.level_invert   = 1'b1;
        c.hilo_reference = 1'b1;
        c.cot_select     = 1'b1;
        apply_cfg(c);
        // enable low with cot set: zero write, then superseded by a drive write
        send_req(10'd1020, 1'b0, 1'b1, 1'b0);
        send_req(10'd3, 1'b0, 1'b0, 1'b0);
        send_req(10'd0, 1'b0, 1'b1, 1'b0);
        send_req(10'd1023, 1'b1, 1'b0, 1'b0);
        send_req(10'd500, 1'b1, 1'b1, 1'b0);
        settle();
        c.manual_enable = 1'b1;
        c.manual_code   = DATA_W'(CODE_MAX);
        apply_cfg(c);
        send_req(10'd300, 1'b0, 1'b1, 1'b1);
        send_req(10'd300, 1'b0, 1'b1, 1'b0);
        send_req(10'd1023, 1'b1, 1'b0, 1'b1);
        settle();
        c.manual_code = '0;
        apply_cfg(c);
        send_req(10'd80, 1'b1, 1'b1, 1'b1);
        send_req(10'd1023, 1'b0, 1'b0, 1'b0);
        settle();
    endtask

    // long climb so the drive reaches its upper limit
    task automatic test_drive_ceiling();
        t_cfg c;
        c = '0;
        c.high_target = DATA_W'(CODE_MAX);
        c.low_target  = DATA_W'(CODE_MAX);
        apply_cfg(c);
        for (int n = 0; n < CEILING_ITEMS; n++) begin
            if (n % 40 == 0) begin
                src_no_gaps   = ($urandom_range(0, 2) == 0);
                snk_no_stalls = ($urandom_range(0, 2) == 0);
            end
            send_req(DATA_W'($urandom_range(0, CODE_MAX - DEAD_BAND - 1)), 1'b0,
                     1'($urandom), 1'($urandom));
        end
        settle();
    endtask

    // climb past the lower limit, then descend until the drive holds
    task automatic test_drive_floor();
        t_cfg c;
        c = '0;
        c.high_target = DATA_W'(CODE_MAX);
        apply_cfg(c);
        src_no_gaps   = 1'b0;
        snk_no_stalls = 1'b0;
        send_req(DATA_W'($urandom_range(0, CODE_MAX)), 1'b1, 1'b1, 1'($urandom));
        send_req(DATA_W'($urandom_range(0, CODE_MAX - DEAD_BAND - 1)), 1'b0, 1'b1,
                 1'($urandom));
        for (int n = 0; n < RAMP_UP_ITEMS; n++) begin
            send_req(DATA_W'($urandom_range(0, CODE_MAX - DEAD_BAND - 1)), 1'b0, 1'b1,
                     1'($urandom));
        end
        for (int n = 0; n < RAMP_DN_ITEMS; n++) begin
            send_req(DATA_W'($urandom_range(DEAD_BAND + 1, CODE_MAX)), 1'b0, 1'b0,
                     1'($urandom));
        end
        settle();
    endtask

    task automatic test_random_traffic();
        t_cfg c;
        logic stby;
        logic hilo;
        int   tgt;
        int   adc;
        int   pick;
        bit   drift_up;
        stby = 1'b0;
        for (int ph = 0; ph < PHASES; ph++) begin
            c.high_target    = pick_code();
            c.low_target     = pick_code();
            c.manual_code    = pick_code();
            c.level_invert   = 1'($urandom);
            c.hilo_reference = 1'($urandom);
            c.cot_select     = 1'($urandom);
            c.pwr_select     = 1'($urandom);
            c.manual_enable  = ($urandom_range(0, 3) == 0);
            apply_cfg(c);
            src_no_gaps   = ($urandom_range(0, 3) == 0);
            snk_no_stalls = ($urandom_range(0, 3) == 0);
            drift_up      = 1'($urandom);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 15) == 0) begin
                    stby = ~stby;
                end
                hilo = 1'($urandom);
                tgt  = int'((c.level_invert ^ (hilo == c.hilo_reference)) ?
                            c.low_target : c.high_target);
                pick = $urandom_range(0, 9);
                if (pick < 4) begin
                    adc = tgt + int'($urandom_range(0, 20)) - 10;
                end else if (pick < 8) begin
                    adc = drift_up ? tgt + int'($urandom_range(DEAD_BAND + 1, 200))
                                   : tgt - int'($urandom_range(DEAD_BAND + 1, 200));
                end else begin
                    adc = int'($urandom_range(0, CODE_MAX));
                end
                if (adc < 0) begin
                    adc = 0;
                end else if (adc > CODE_MAX) begin
                    adc = CODE_MAX;
                end
                send_req(DATA_W'(adc), stby, hilo, 1'($urandom));
            end
            settle();
        end
    endtask

    task automatic check_result(t_res got);
        t_res want;
        if (loop_result_q.size() == 0) begin
            report_mismatch("result with no request outstanding", 1, 0);
            return;
        end
        want = loop_result_q.pop_front();
        if (got.dac_write !== want.dac_write)
            report_mismatch("dac_write", got.dac_write, want.dac_write);
        if (got.dac_code !== want.dac_code)
            report_mismatch("dac_code", got.dac_code, want.dac_code);
        if (got.power_enable !== want.power_enable)
            report_mismatch("power_enable", got.power_enable, want.power_enable);
        if (got.reinit_request !== want.reinit_request)
            report_mismatch("reinit_request", got.reinit_request, want.reinit_request);
        if (got.power_valid !== want.power_valid)
            report_mismatch("power_valid", got.power_valid, want.power_valid);
        if (got.power_reading !== want.power_reading)
            report_mismatch("power_reading", got.power_reading, want.power_reading);
    endtask

    // result side
    initial begin
        int   stall;
        t_res got;
        out_bus.ready <= 1'b0;
        @(posedge clk);
        while (rst_n !== 1'b1) @(posedge clk);
        forever begin
            stall = snk_no_stalls ? 0 : $urandom_range(0, GAP_MAX);
            if (stall > 0) begin
                out_bus.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_bus.ready <= 1'b1;
            @(posedge clk);
            while (out_bus.valid !== 1'b1) @(posedge clk);
            got.dac_write      = out_bus.dac_write;
            got.dac_code       = out_bus.dac_code;
            got.power_enable   = out_bus.power_enable;
            got.reinit_request = out_bus.reinit_request;
            got.power_valid    = out_bus.power_valid;
            got.power_reading  = out_bus.power_reading;
            check_result(got);
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((in_bus.valid === 1'b1 && in_bus.ready === 1'b1) ||
                (out_bus.valid === 1'b1 && out_bus.ready === 1'b1)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        rst_n                <= 1'b0;
        cfg_we               <= 1'b0;
        cfg_idx              <= '0;
        cfg_data             <= '0;
        in_bus.valid         <= 1'b0;
        in_bus.adc_sample    <= '0;
        in_bus.standby_level <= 1'b0;
        in_bus.hilo_level    <= 1'b0;
        in_bus.tick_100ms    <= 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_deadband_edges();
        test_zero_write_and_manual();
        test_drive_ceiling();
        test_drive_floor();
        test_random_traffic();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+src
src/rpdl_pkg.sv
src/rpdl_in_if.sv
src/rpdl_out_if.sv
src/rpdl_step.sv
src/rf_power_deadband_loop.sv
src/rpdl_chk.sv
tb/sv/tb_top.sv
